FILE: hw/rtl/block_average_downscaler_core_macros.svh
// Assertion macros for the block average downscaler.
// Used by the core top level; expects clk and arst_n in scope.
`ifndef BLOCK_AVERAGE_DOWNSCALER_CORE_MACROS_SVH
`define BLOCK_AVERAGE_DOWNSCALER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BAVG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define BAVG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/bavg_pkg.sv
// Shared types, field widths, register codes and reciprocal table
// for the block average downscaler. No dependencies.
`default_nettype none

package bavg_pkg;

	// Fixed field and register widths
	localparam int SAMPLE_W       = 8;
	localparam int CHIDX_W        = 2;
	localparam int LINE_WIDTH_W   = 12;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CC_W           = 3;
	localparam int BS_W           = 4;
	localparam int ROW_W          = 12;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;

	localparam int FRAME_ROWS_MAX = 4096;

	// Register reset values
	localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 12'd1920;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
	localparam logic [CC_W-1:0]           CHANNEL_CNT_RST  = 3'd3;
	localparam logic [BS_W-1:0]           BLOCK_SIZE_RST   = 4'd3;

	// Register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH,
		CFG_FRAME_HEIGHT,
		CFG_CHANNEL_COUNT,
		CFG_BLOCK_SIZE
	} bavg_cfg_idx_t;

	// ceil(2^24 / (bs*bs)), exact truncated quotient for sums below 2^16
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 24;
	localparam logic [RECIP_W-1:0] RECIP_TABLE [16] = '{
		25'd16777216, 25'd16777216, 25'd4194304, 25'd1864136,
		25'd1048576,  25'd671089,   25'd466034,  25'd342393,
		25'd262144,   25'd207127,   25'd167773,  25'd138655,
		25'd116509,   25'd99274,    25'd85599,   25'd74566
	};

	// Result sideband carried along the pipeline
	typedef struct packed {
		logic [CHIDX_W-1:0] channel_index;
		logic               row_end;
		logic               frame_end;
	} bavg_res_info_t;

	// Band divider status
	typedef struct packed {
		logic busy;
		logic done;
	} bavg_div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bavg_intf.sv
// Channel interfaces: sample input, average output, configuration write.
// Depends on bavg_pkg.
`default_nettype none

interface bavg_in_if
	import bavg_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                frame_start;

	modport source (output valid, output sample, output frame_start, input ready);
	modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface bavg_out_if
	import bavg_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] average;
	logic [CHIDX_W-1:0]  channel_index;
	logic                row_end;
	logic                frame_end;

	modport source (output valid, output average, output channel_index,
		output row_end, output frame_end, input ready);
	modport sink (input valid, input average, input channel_index,
		input row_end, input frame_end, output ready);
endinterface

interface bavg_cfg_if
	import bavg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bavg_sum_ram.sv
// Column sum memory: one write port, one registered read port, with
// forwarding of the most recent write. Depends on nothing.
`default_nettype none

module bavg_sum_ram #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 14
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [DATA_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic [DATA_W-1:0] lw_data_q;

	// Storage: read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Last write, for a read that raced it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr_en) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
	end

	assign rd_data = (lw_valid_q && (lw_addr_q == rd_addr_q)) ? lw_data_q : rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bavg_band_div.sv
// Restoring divider, one quotient bit a cycle: input row over block size.
// Rebuilds band index and row-in-band after a block size change. Uses bavg_pkg.
`default_nettype none

module bavg_band_div
	import bavg_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [ROW_W-1:0] dividend,
	input  wire logic [BS_W-1:0]  divisor,
	output bavg_div_status_t      status,
	output logic      [ROW_W-1:0] quotient,
	output logic      [BS_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(ROW_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROW_W-1:0] shreg_q;
	logic [BS_W-1:0]  rem_q;
	logic [BS_W-1:0]  div_q;
	logic [BS_W:0]    trial;
	logic             take;

	// One trial subtraction
	assign trial = {rem_q, shreg_q[ROW_W-1]};
	assign take  = trial >= {1'b0, div_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(ROW_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= dividend;
			rem_q   <= '0;
			div_q   <= divisor;
		end else if (busy_q) begin
			shreg_q <= {shreg_q[ROW_W-2:0], take};
			rem_q   <= take ? BS_W'(trial - {1'b0, div_q}) : trial[BS_W-1:0];
		end
	end

	assign status.busy = busy_q | done_q;
	assign status.done = done_q;
	assign quotient    = shreg_q;
	assign remainder   = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bavg_avg_out.sv
// Average stage: block sum times reciprocal of block area, then the
// output register toward the result channel. Uses bavg_pkg and bavg_out_if.
`default_nettype none

module bavg_avg_out
	import bavg_pkg::*;
#(
	parameter int SUM_W = 14
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [SUM_W-1:0] push_sum,
	input  bavg_res_info_t        push_info,
	input  wire logic [BS_W-1:0]  block_size,
	bavg_out_if.source            averages
);

	localparam int PROD_W = SUM_W + RECIP_W;

	logic                valid_s2;
	logic [SUM_W-1:0]    sum_s2;
	bavg_res_info_t      info_s2;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] avg_q;
	bavg_res_info_t      info_q;
	logic                out_free;
	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    quo;
	logic [SAMPLE_W-1:0] avg;

	assign out_free   = !out_valid_q || averages.ready;
	assign push_ready = !valid_s2 || out_free;

	// Sum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (push_ready) begin
			valid_s2 <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ready && push_valid) begin
			sum_s2  <= push_sum;
			info_s2 <= push_info;
		end
	end

	// Division by block area through the reciprocal, saturated to 8 bits
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP_TABLE[block_size]);
	assign quo  = prod[RECIP_SHIFT +: SUM_W];
	assign avg  = (quo > SUM_W'(255)) ? 8'hFF : quo[SAMPLE_W-1:0];

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			avg_q  <= avg;
			info_q <= info_s2;
		end
	end

	assign averages.valid         = out_valid_q;
	assign averages.average       = avg_q;
	assign averages.channel_index = info_q.channel_index;
	assign averages.row_end       = info_q.row_end;
	assign averages.frame_end     = info_q.frame_end;

endmodule

`default_nettype wire

FILE: hw/rtl/block_average_downscaler_core.sv
// Block average downscaler core: position tracking, column sum RMW, averaging.
// A result passes stage 1, the sum register and the output register before it is valid.
// Throughput: one sample per cycle unless the output or the band divider stalls, set by the
// read-modify-write of the column sum memory (registered read, forwarding of the last write).
// A block_size write holds samples.ready low while the band divider runs.
// Reset clears counters and pipeline valids and loads the register reset values; the sum memory is not cleared.
`default_nettype none

`include "block_average_downscaler_core_macros.svh"

module block_average_downscaler_core
	import bavg_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 2048,
	parameter int MAX_CHANNELS   = 4,
	parameter int MAX_BLOCK      = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bavg_cfg_if.sink  cfg,
	bavg_in_if.sink   samples,
	bavg_out_if.source averages
);

	localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int COL_W    = $clog2(MAX_LINE_WIDTH);
	localparam int LW_W     = $clog2(MAX_LINE_WIDTH + 1);
	localparam int LW_CMP_W = (LW_W > LINE_WIDTH_W) ? LW_W : LINE_WIDTH_W;
	localparam int BLK_W    = $clog2(MAX_BLOCK);
	localparam int SUM_W    = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
	localparam int ADDR_W   = COL_W + CH_W;
	localparam int CP_W     = COL_W + BS_W + 2;
	localparam int RP_W     = ROW_W + BS_W + 2;

	// Configuration registers
	logic [LINE_WIDTH_W-1:0]   line_width_q;
	logic [FRAME_HEIGHT_W-1:0] frame_height_q;
	logic [CC_W-1:0]           channel_count_q;
	logic [BS_W-1:0]           block_size_q;
	logic                      div_start_q;

	// Position state
	logic [CH_W-1:0]  ch_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] ocol_q;
	logic [BLK_W-1:0] cib_q;
	logic [ROW_W-1:0] row_q;
	logic [BLK_W-1:0] rib_q;
	logic [ROW_W-1:0] band_q;
	logic [BLK_W-1:0] brem_q;

	// Clamped registers
	logic [LW_W-1:0]           lw_eff;
	logic [LW_CMP_W-1:0]       lw_wide;
	logic [FRAME_HEIGHT_W-1:0] fh_eff;
	logic [CC_W-1:0]           cc_eff;
	logic [BS_W-1:0]           bs_eff;

	// Positions after frame_start
	logic [CH_W-1:0]  ch0;
	logic [COL_W-1:0] col0;
	logic [COL_W-1:0] ocol0;
	logic [BLK_W-1:0] cib0;
	logic [ROW_W-1:0] row0;
	logic [BLK_W-1:0] rib0;
	logic [ROW_W-1:0] band0;
	logic [BLK_W-1:0] brem0;

	// Next positions
	logic [CH_W-1:0]  ch_d;
	logic [COL_W-1:0] col_d;
	logic [COL_W-1:0] ocol_d;
	logic [BLK_W-1:0] cib_d;
	logic [ROW_W-1:0] row_d;
	logic [BLK_W-1:0] rib_d;
	logic [ROW_W-1:0] band_d;
	logic [BLK_W-1:0] brem_d;

	// Decisions for the current sample
	logic [CP_W-1:0] col_end1;
	logic [CP_W-1:0] col_end2;
	logic [RP_W-1:0] row_end1;
	logic [RP_W-1:0] row_end2;
	logic            ch_more;
	logic            col_more;
	logic            row_last;
	logic            cib_wrap;
	logic            rib_wrap;
	logic            brem_wrap;
	logic            proc;
	logic            first;
	logic            res;
	bavg_res_info_t  info;
	logic            accept;

	// Stage 1: memory data and sum
	logic              valid_s1;
	logic              proc_s1;
	logic              first_s1;
	logic              res_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [ADDR_W-1:0] addr_s1;
	bavg_res_info_t    info_s1;
	logic              s1_adv;
	logic              s1_free;
	logic              push_ready;
	logic              wr_en;
	logic [SUM_W-1:0]  rd_data;
	logic [SUM_W-1:0]  sum;

	bavg_div_status_t  div_stat;
	logic [ROW_W-1:0]  div_quo;
	logic [BS_W-1:0]   div_rem;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q    <= LINE_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			channel_count_q <= CHANNEL_CNT_RST;
			block_size_q    <= BLOCK_SIZE_RST;
			div_start_q     <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg.valid) begin
				case (bavg_cfg_idx_t'(cfg.index))
					CFG_LINE_WIDTH: begin
						line_width_q <= cfg.data[LINE_WIDTH_W-1:0];
					end
					CFG_FRAME_HEIGHT: begin
						frame_height_q <= cfg.data[FRAME_HEIGHT_W-1:0];
					end
					CFG_CHANNEL_COUNT: begin
						channel_count_q <= cfg.data[CC_W-1:0];
					end
					CFG_BLOCK_SIZE: begin
						block_size_q <= cfg.data[BS_W-1:0];
						div_start_q  <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Saturate registers into their working ranges
	always_comb begin
		if (line_width_q == '0) begin
			lw_wide = LW_CMP_W'(1);
		end else if (LW_CMP_W'(line_width_q) > LW_CMP_W'(MAX_LINE_WIDTH)) begin
			lw_wide = LW_CMP_W'(MAX_LINE_WIDTH);
		end else begin
			lw_wide = LW_CMP_W'(line_width_q);
		end
		lw_eff = LW_W'(lw_wide);

		if (frame_height_q == '0) begin
			fh_eff = FRAME_HEIGHT_W'(1);
		end else if (frame_height_q > FRAME_HEIGHT_W'(FRAME_ROWS_MAX)) begin
			fh_eff = FRAME_HEIGHT_W'(FRAME_ROWS_MAX);
		end else begin
			fh_eff = frame_height_q;
		end

		if (channel_count_q == '0) begin
			cc_eff = CC_W'(1);
		end else if (channel_count_q > CC_W'(MAX_CHANNELS)) begin
			cc_eff = CC_W'(MAX_CHANNELS);
		end else begin
			cc_eff = channel_count_q;
		end

		if (block_size_q == '0) begin
			bs_eff = BS_W'(1);
		end else if ({1'b0, block_size_q} > (BS_W + 1)'(MAX_BLOCK)) begin
			bs_eff = BS_W'(MAX_BLOCK);
		end else begin
			bs_eff = block_size_q;
		end
	end

	// Frame start clears the position before use
	always_comb begin
		ch0   = samples.frame_start ? '0 : ch_q;
		col0  = samples.frame_start ? '0 : col_q;
		ocol0 = samples.frame_start ? '0 : ocol_q;
		cib0  = samples.frame_start ? '0 : cib_q;
		row0  = samples.frame_start ? '0 : row_q;
		rib0  = samples.frame_start ? '0 : rib_q;
		band0 = samples.frame_start ? '0 : band_q;
		brem0 = samples.frame_start ? '0 : brem_q;
	end

	// Block fit tests: end of this block and of the next one against the frame
	assign col_end1 = CP_W'({1'b0, ocol0} + 1'b1) * CP_W'(bs_eff);
	assign col_end2 = col_end1 + CP_W'(bs_eff);
	assign row_end1 = RP_W'({1'b0, band0} + 1'b1) * RP_W'(bs_eff);
	assign row_end2 = row_end1 + RP_W'(bs_eff);

	assign ch_more   = (CC_W'(ch0) + CC_W'(1)) < cc_eff;
	assign col_more  = ((COL_W + 1)'(col0) + (COL_W + 1)'(1)) < (COL_W + 1)'(lw_eff);
	assign row_last  = ((FRAME_HEIGHT_W)'(row0) + FRAME_HEIGHT_W'(1)) >= fh_eff;
	assign cib_wrap  = ((BS_W + 1)'(cib0) + (BS_W + 1)'(1)) >= (BS_W + 1)'(bs_eff);
	assign rib_wrap  = ((BS_W + 1)'(rib0) + (BS_W + 1)'(1)) >= (BS_W + 1)'(bs_eff);
	assign brem_wrap = ((BS_W + 1)'(brem0) + (BS_W + 1)'(1)) >= (BS_W + 1)'(bs_eff);

	assign proc  = (col_end1 <= CP_W'(lw_eff)) && (row_end1 <= RP_W'(fh_eff))
		&& (CC_W'(ch0) < cc_eff);
	assign first = (rib0 == '0) && (cib0 == '0);
	assign res   = proc && rib_wrap && cib_wrap;

	assign info.channel_index = CHIDX_W'(ch0);
	assign info.row_end       = (col_end2 > CP_W'(lw_eff)) && !ch_more;
	assign info.frame_end     = info.row_end && (row_end2 > RP_W'(fh_eff));

	// Position advance
	always_comb begin
		ch_d   = ch0;
		col_d  = col0;
		ocol_d = ocol0;
		cib_d  = cib0;
		row_d  = row0;
		rib_d  = rib0;
		band_d = band0;
		brem_d = brem0;
		if (ch_more) begin
			ch_d = ch0 + CH_W'(1);
		end else begin
			ch_d = '0;
			if (col_more) begin
				col_d = col0 + COL_W'(1);
				if (cib_wrap) begin
					cib_d  = '0;
					ocol_d = ocol0 + COL_W'(1);
				end else begin
					cib_d = cib0 + BLK_W'(1);
				end
			end else begin
				col_d  = '0;
				cib_d  = '0;
				ocol_d = '0;
				if (row_last) begin
					row_d  = '0;
					rib_d  = '0;
					band_d = '0;
					brem_d = '0;
				end else begin
					row_d = row0 + ROW_W'(1);
					rib_d = rib_wrap ? '0 : rib0 + BLK_W'(1);
					if (brem_wrap) begin
						brem_d = '0;
						band_d = band0 + ROW_W'(1);
					end else begin
						brem_d = brem0 + BLK_W'(1);
					end
				end
			end
		end
	end

	// Input handshake
	assign s1_adv        = valid_s1 && (!res_s1 || push_ready);
	assign s1_free       = !valid_s1 || s1_adv;
	assign samples.ready = s1_free && !div_start_q && !div_stat.busy;
	assign accept        = samples.valid && samples.ready;

	// Position registers; the divider rebuilds the band after a block size change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= '0;
			col_q  <= '0;
			ocol_q <= '0;
			cib_q  <= '0;
			row_q  <= '0;
			rib_q  <= '0;
			band_q <= '0;
			brem_q <= '0;
		end else if (accept) begin
			ch_q   <= ch_d;
			col_q  <= col_d;
			ocol_q <= ocol_d;
			cib_q  <= cib_d;
			row_q  <= row_d;
			rib_q  <= rib_d;
			band_q <= band_d;
			brem_q <= brem_d;
		end else if (div_stat.done) begin
			band_q <= div_quo;
			brem_q <= BLK_W'(div_rem);
		end
	end

	bavg_band_div u_band_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (row_q),
		.divisor   (bs_eff),
		.status    (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			proc_s1   <= proc;
			first_s1  <= first;
			res_s1    <= res;
			sample_s1 <= samples.sample;
			addr_s1   <= {ocol0, ch0};
			info_s1   <= info;
		end
	end

	// Read-modify-write of the column sum
	bavg_sum_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (SUM_W)
	) u_sum_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr ({ocol0, ch0}),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (sum),
		.rd_data (rd_data)
	);

	assign sum   = first_s1 ? SUM_W'(sample_s1) : rd_data + SUM_W'(sample_s1);
	assign wr_en = s1_adv && proc_s1;

	bavg_avg_out #(
		.SUM_W (SUM_W)
	) u_avg_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (valid_s1 && res_s1),
		.push_ready (push_ready),
		.push_sum   (sum),
		.push_info  (info_s1),
		.block_size (bs_eff),
		.averages   (averages)
	);

	// Checks
	`BAVG_ASSERT_NXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(addr_s1), "stalled stage 1 item lost")
	`BAVG_ASSERT_NXT(a_bs_write_blocks, cfg.valid && cfg.ready && (cfg.index == CFG_BLOCK_SIZE), !samples.ready, "sample taken before band rebuild")
	`BAVG_ASSERT_IMP(a_write_from_item, wr_en, valid_s1, "sum write without an item")
	`BAVG_ASSERT_NXT(a_accept_fills_s1, accept, valid_s1, "accepted sample missing in stage 1")

endmodule

`default_nettype wire
